// File: sv/time_of_day_duty_schedule_macros.svh
// Assertion macros for the time-of-day duty schedule block.
// A macro expects clk and rst_n in the scope where it is used.
`ifndef TIME_OF_DAY_DUTY_SCHEDULE_MACROS_SVH
`define TIME_OF_DAY_DUTY_SCHEDULE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define TODS_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tods: check failed");

// next-cycle implication
`define TODS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tods: check failed");

`else

`define TODS_ASSERT(label, ante, cons)
`define TODS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/tods_pkg.sv
`timescale 1ns / 1ps

package tods_pkg;

    localparam int SLOT_COUNT_DEF   = 144;
    localparam int BITMAP_BYTES_DEF = 18;

    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int SLOTS_PER_HR  = 6;
    localparam int MIN_PER_SLOT  = 10;
    localparam int SLOT_SECONDS  = MIN_PER_SLOT * SEC_PER_MIN;
    localparam int IDLE_W        = 17;

    // largest hour*6 + minute/10 + 1 from 5-bit hour and 6-bit minute
    localparam int SLOT_RAW_MAX  = 31 * SLOTS_PER_HR + 63 / MIN_PER_SLOT + 1;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_SCHED = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [4:0]        hour_now;
        logic [5:0]        minute_now;
        logic [5:0]        second_now;
        logic [15:0]       day_count;
        logic              active_now;
        logic              rose_active;
        logic [31:0]       active_seconds;
        logic [IDLE_W-1:0] idle_seconds;
    } result_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    function automatic logic [2:0] div10(input logic [5:0] m);
        logic [2:0] q;
        q = 3'd0;
        if (m >= 6'd10) q = 3'd1;
        if (m >= 6'd20) q = 3'd2;
        if (m >= 6'd30) q = 3'd3;
        if (m >= 6'd40) q = 3'd4;
        if (m >= 6'd50) q = 3'd5;
        if (m >= 6'd60) q = 3'd6;
        return q;
    endfunction

    function automatic logic [3:0] mod10(input logic [5:0] m);
        logic [5:0] tens;
        tens = 6'(div10(m)) * 6'(MIN_PER_SLOT);
        return 4'(m - tens);
    endfunction

endpackage

// File: sv/tods_time.sv
`timescale 1ns / 1ps

module tods_time (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick,
    input  logic            load,
    input  tods_pkg::tod_t  load_time,
    output tods_pkg::tod_t  now,
    output logic [15:0]     days
);
    import tods_pkg::*;

    tod_t        time_reg;
    tod_t        time_next;
    logic [15:0] days_reg;
    logic [15:0] days_next;

    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;

    always_comb
    begin
        time_next = time_reg;
        days_next = days_reg;
        sec_inc   = {1'b0, time_reg.second} + 7'd1;
        min_inc   = {1'b0, time_reg.minute};
        hour_inc  = {1'b0, time_reg.hour};

        // carries ripple second -> minute -> hour -> day
        if (sec_inc >= 7'(SEC_PER_MIN))
        begin
            time_next.second = 6'd0;
            min_inc          = min_inc + 7'd1;
        end
        else
        begin
            time_next.second = sec_inc[5:0];
        end

        if (min_inc >= 7'(MIN_PER_HOUR))
        begin
            time_next.minute = 6'd0;
            hour_inc         = hour_inc + 6'd1;
        end
        else
        begin
            time_next.minute = min_inc[5:0];
        end

        if (hour_inc >= 6'(HOUR_PER_DAY))
        begin
            time_next.hour = 5'd0;
            days_next      = days_reg + 16'd1;
        end
        else
        begin
            time_next.hour = hour_inc[4:0];
        end

        if (!tick)
        begin
            time_next = load ? load_time : time_reg;
            days_next = days_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            days_reg <= '0;
        end
        else
        begin
            time_reg <= time_next;
            days_reg <= days_next;
        end
    end

    assign now  = time_reg;
    assign days = days_reg;

endmodule

// File: sv/tods_bitmap.sv
`timescale 1ns / 1ps

module tods_bitmap #(
    parameter int SLOT_COUNT   = tods_pkg::SLOT_COUNT_DEF,
    parameter int BITMAP_BYTES = tods_pkg::BITMAP_BYTES_DEF,
    parameter int SLOT_W       = $clog2(SLOT_COUNT + tods_pkg::SLOT_RAW_MAX + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [4:0]        wr_index,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_slot,
    output logic [7:0]        rd_byte
);
    import tods_pkg::*;

    localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

    logic [7:0]              mem [BITMAP_BYTES];
    logic [BITMAP_BYTES-1:0] valid_reg;
    logic [7:0]              data_reg;
    logic                    ok_reg;

    logic                    wr_ok;
    logic [AW-1:0]           wr_addr;
    logic [SLOT_W-4:0]       rd_byte_num;
    logic                    rd_in_range;
    logic [AW-1:0]           rd_addr;

    assign wr_ok       = 32'(wr_index) < BITMAP_BYTES;
    assign wr_addr     = AW'(wr_index);
    assign rd_byte_num = rd_slot[SLOT_W-1:3];
    assign rd_in_range = 32'(rd_byte_num) < BITMAP_BYTES;
    assign rd_addr     = AW'(rd_byte_num);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // never-written bytes read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                ok_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_byte = ok_reg ? data_reg : 8'd0;

endmodule

// File: sv/time_of_day_duty_schedule.sv
`timescale 1ns / 1ps

// Time-of-day duty schedule. A tick word advances the clock by one second and
// re-evaluates the active flag (network_ready AND the current 10-minute slot
// bit); a set word loads the time; a schedule word writes one bitmap byte. One
// result word follows every item. Busy time per item is set by the idle scan,
// which walks the slot bitmap one bit per cycle, save when it stops to read a
// new byte through a single byte-wide read port: after a fixed setup and the
// slot wrap, it takes one step per scheduled slot in the run plus one bitmap
// read per byte touched, and it is skipped when the flag is clear. The block
// takes no new word while busy; a finished result waits in an output register.
module time_of_day_duty_schedule #(
    parameter int SLOT_COUNT   = tods_pkg::SLOT_COUNT_DEF,
    parameter int BITMAP_BYTES = tods_pkg::BITMAP_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  tods_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tods_pkg::result_t result
);
    import tods_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT + SLOT_RAW_MAX + 1);
    localparam int RUN_W  = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_TICK_RD  = 3'd1;
    localparam logic [2:0] ST_TICK_EV  = 3'd2;
    localparam logic [2:0] ST_CALC     = 3'd3;
    localparam logic [2:0] ST_MOD      = 3'd4;
    localparam logic [2:0] ST_SCAN_RD  = 3'd5;
    localparam logic [2:0] ST_SCAN_BIT = 3'd6;
    localparam logic [2:0] ST_FIN      = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic              net_ready_reg;
    logic              active_reg;
    logic              active_next;
    logic              rose_reg;
    logic              rose_next;
    logic [31:0]       count_reg;
    logic [31:0]       count_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic [IDLE_W-1:0] idle_reg;
    logic [IDLE_W-1:0] idle_next;
    result_t           result_reg;
    result_t           result_next;
    logic              result_valid_reg;
    logic              result_valid_next;

    logic              accept;
    tod_t              now;
    tod_t              load_time;
    logic [15:0]       days;

    logic              bm_rd_en;
    logic [SLOT_W-1:0] bm_rd_slot;
    logic [7:0]        bm_rd_byte;

    logic [7:0]        raw_slot;
    logic              slot_bit;
    logic [SLOT_W-1:0] slot_inc;
    logic [5:0]        sec_part;
    logic [9:0]        idle_init;
    logic [IDLE_W:0]   idle_sum;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    assign load_time.hour   = item.set_hour;
    assign load_time.minute = item.set_minute;
    assign load_time.second = item.set_second;

    tods_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (accept && (item.kind == KIND_TICK)),
        .load      (accept && (item.kind == KIND_SET)),
        .load_time (load_time),
        .now       (now),
        .days      (days)
    );

    tods_bitmap #(
        .SLOT_COUNT   (SLOT_COUNT),
        .BITMAP_BYTES (BITMAP_BYTES),
        .SLOT_W       (SLOT_W)
    ) u_bitmap (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && (item.kind == KIND_SCHED)),
        .wr_index (item.byte_index),
        .wr_data  (item.byte_value),
        .rd_en    (bm_rd_en),
        .rd_slot  (bm_rd_slot),
        .rd_byte  (bm_rd_byte)
    );

    assign raw_slot  = 8'(now.hour) * 8'(SLOTS_PER_HR) + 8'(div10(now.minute));
    assign slot_bit  = (32'(slot_reg) < SLOT_COUNT) && bm_rd_byte[3'd7 - slot_reg[2:0]];
    assign slot_inc  = slot_reg + SLOT_W'(1);
    assign sec_part  = (now.second < 6'(SEC_PER_MIN)) ? 6'(SEC_PER_MIN) - now.second : 6'd0;
    assign idle_init = 10'(4'(MIN_PER_SLOT - 1) - mod10(now.minute)) * 10'(SEC_PER_MIN)
                       + 10'(sec_part);
    assign idle_sum  = (IDLE_W + 1)'(idle_reg) + (IDLE_W + 1)'(SLOT_SECONDS);

    assign bm_rd_en   = (state_reg == ST_TICK_RD) || (state_reg == ST_SCAN_RD);
    assign bm_rd_slot = (state_reg == ST_TICK_RD) ? SLOT_W'(raw_slot) : slot_reg;

    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        rose_next         = rose_reg;
        count_next        = count_reg;
        slot_next         = slot_reg;
        run_next          = run_reg;
        idle_next         = idle_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rose_next  = 1'b0;
                    state_next = (item.kind == KIND_TICK) ? ST_TICK_RD : ST_CALC;
                end
            end
            ST_TICK_RD:
            begin
                slot_next  = SLOT_W'(raw_slot);
                state_next = ST_TICK_EV;
            end
            ST_TICK_EV:
            begin
                active_next = net_ready_reg && slot_bit;
                if (active_next && !active_reg)
                begin
                    rose_next  = 1'b1;
                    count_next = 32'd1;
                end
                else if (active_next)
                begin
                    count_next = count_reg + 32'd1;
                end
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (!active_reg)
                begin
                    idle_next  = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    slot_next  = SLOT_W'(raw_slot) + SLOT_W'(1);
                    idle_next  = IDLE_W'(idle_init);
                    run_next   = '0;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (32'(slot_reg) >= SLOT_COUNT)
                begin
                    slot_next = slot_reg - SLOT_W'(SLOT_COUNT);
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_BIT;
            end
            ST_SCAN_BIT:
            begin
                if ((32'(run_reg) == SLOT_COUNT) || !slot_bit)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idle_next = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];
                    run_next  = run_reg + RUN_W'(1);
                    slot_next = (32'(slot_inc) == SLOT_COUNT) ? '0 : slot_inc;
                    // a new byte is needed at each byte boundary and at wrap
                    if (slot_next[2:0] == 3'd0)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.hour_now       = now.hour;
                    result_next.minute_now     = now.minute;
                    result_next.second_now     = now.second;
                    result_next.day_count      = days;
                    result_next.active_now     = active_reg;
                    result_next.rose_active    = rose_reg;
                    result_next.active_seconds = count_reg;
                    result_next.idle_seconds   = idle_reg;
                    result_valid_next          = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            net_ready_reg    <= 1'b0;
            active_reg       <= 1'b1;
            rose_reg         <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_reg       <= active_next;
            rose_reg         <= rose_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                net_ready_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        run_reg    <= run_next;
        idle_reg   <= idle_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "time_of_day_duty_schedule_macros.svh"

    `TODS_ASSERT(a_rose_active, result_valid && result.rose_active, result.active_now)
    `TODS_ASSERT(a_idle_active, result_valid && (result.idle_seconds != '0), result.active_now)
    `TODS_ASSERT(a_run_bound, state_reg == ST_SCAN_BIT, 32'(run_reg) <= SLOT_COUNT)
    `TODS_ASSERT(a_scan_slot, state_reg == ST_SCAN_BIT, 32'(slot_reg) < SLOT_COUNT)
    `TODS_ASSERT_NEXT(a_busy_after_accept, accept, !item_ready)

endmodule
